>>> rtl/sdsplit_pkg.sv
`default_nettype none
package sdsplit_pkg;

	localparam int MAX_DELIM = 8;
	localparam int FILL_W = $clog2(MAX_DELIM);
	localparam int LEN_W = $clog2(MAX_DELIM + 1);
	localparam int DBYTE_N = 8;
	localparam int DELIM_W = 8 * DBYTE_N;
	localparam int CFG_W = 2;

	localparam logic [CFG_W-1:0] CFG_DELIM_LEN = 2'd0;
	localparam logic [CFG_W-1:0] CFG_DELIM_BYTES = 2'd1;
	localparam logic [CFG_W-1:0] CFG_MAX_SPLITS = 2'd2;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef enum logic [1:0] {
		PH_RUN,
		PH_FLUSH,
		PH_MARK
	} phase_t;

	typedef struct packed {
		logic       shift;
		logic [7:0] new_byte;
	} cell_ctl_t;

endpackage
`default_nettype wire

>>> rtl/sdsplit_cell.sv
`default_nettype none
module sdsplit_cell (
	input  wire logic                  clk,
	input  wire sdsplit_pkg::cell_ctl_t ctl,
	input  wire logic                  sel,
	input  wire logic                  cmp_en,
	input  wire logic [7:0]            delim_byte,
	input  wire logic [7:0]            right_byte,
	output logic      [7:0]            eff_byte,
	output logic                       eq
);

	logic [7:0] byte_q;

	// the byte this cell holds once the incoming byte is written in
	assign eff_byte = sel ? ctl.new_byte : byte_q;
	assign eq = !cmp_en || (eff_byte == delim_byte);

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			byte_q <= right_byte;
		end else if (sel) begin
			byte_q <= ctl.new_byte;
		end
	end

endmodule
`default_nettype wire

>>> rtl/sdsplit_window.sv
`default_nettype none
module sdsplit_window (
	input  wire logic                                clk,
	input  wire sdsplit_pkg::cell_ctl_t               ctl,
	input  wire logic [sdsplit_pkg::MAX_DELIM-1:0]   sel,
	input  wire logic [sdsplit_pkg::LEN_W-1:0]       len_eff,
	input  wire logic [sdsplit_pkg::DELIM_W-1:0]     delim_bytes,
	output logic      [7:0]                          oldest,
	output logic                                     all_eq
);

	logic [7:0] eff [sdsplit_pkg::MAX_DELIM+1];
	logic [sdsplit_pkg::MAX_DELIM-1:0] eq;

	assign eff[sdsplit_pkg::MAX_DELIM] = 8'd0;

	for (genvar k = 0; k < sdsplit_pkg::MAX_DELIM; k++) begin : g_cell
		logic [7:0] dbyte;
		logic       cmp_en;

		if (k < sdsplit_pkg::DBYTE_N) begin : g_db
			assign dbyte = delim_bytes[8*k +: 8];
		end else begin : g_zero
			assign dbyte = 8'd0;
		end

		assign cmp_en = sdsplit_pkg::LEN_W'(k) < len_eff;

		sdsplit_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.sel        (sel[k]),
			.cmp_en     (cmp_en),
			.delim_byte (dbyte),
			.right_byte (eff[k+1]),
			.eff_byte   (eff[k]),
			.eq         (eq[k])
		);
	end

	assign oldest = eff[0];
	assign all_eq = &eq;

endmodule
`default_nettype wire

>>> rtl/streaming_delimiter_splitter.sv
// Delimiter splitter for byte streams.
// Input: one string byte per transfer on s_axis, tlast on the final byte.
// Output: m_axis carries one result per transfer; tuser is 0 for a field
// byte (tdata holds it) and 1 for a field-end marker (tdata zero); tlast
// flags the final result of the string.
// Config: cfg_valid/cfg_index/cfg_data, always ready; index 0 delimiter
// length, 1 delimiter bytes, 2 split limit (0 = none). Write while idle.
// Held-back bytes sit in a row of eight cells that shift toward the output
// and compare against the delimiter in place.
// Throughput: one byte per cycle while m_axis is ready, except that the last
// byte of a string is held until the bytes left in the window after its
// compare have drained through the single output register, followed by the
// closing marker when the last field holds any byte. Lowering the delimiter
// length mid-string drains each surplus byte before the held byte is compared.
// A byte taken from s_axis is registered in a holding register, and its
// results are registered in the output register that drives m_axis.
// Reset clears the string state and sets length 1, delimiter 0, no limit.
// A stall on m_axis holds the current result; one more input byte is still
// taken and held until the output frees.
`default_nettype none
module streaming_delimiter_splitter (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_axis_tvalid,
	output logic                                s_axis_tready,
	input  wire logic [7:0]                     s_axis_tdata,  // data_byte
	input  wire logic                           s_axis_tlast,  // is_last
	output logic                                m_axis_tvalid,
	input  wire logic                           m_axis_tready,
	output logic      [7:0]                     m_axis_tdata,  // out_byte
	output logic                                m_axis_tuser,  // kind
	output logic                                m_axis_tlast,  // end_of_string
	input  wire logic                           cfg_valid,
	output logic                                cfg_ready,
	input  wire logic [sdsplit_pkg::CFG_W-1:0]  cfg_index,
	input  wire logic [63:0]                    cfg_data
);

	localparam int FW = sdsplit_pkg::FILL_W;
	localparam int LW = sdsplit_pkg::LEN_W;

	logic [3:0]                      dlen_q;
	logic [sdsplit_pkg::DELIM_W-1:0] dbytes_q;
	logic [15:0]                     maxs_q;

	logic                 pend_q;
	logic [7:0]           pbyte_q;
	logic                 plast_q;
	sdsplit_pkg::phase_t  phase_q, phase_d;

	logic [FW-1:0] fill_q, fill_d;
	logic          ne_q, ne_d;
	logic [15:0]   splits_q, splits_d, splits_inc;
	logic          stopped_q, stopped_d;

	logic       out_valid_q, out_kind_q, out_eos_q;
	logic [7:0] out_byte_q;

	logic                              fire, done, run_end, emit, emit_kind;
	logic [7:0]                        emit_byte;
	logic [LW-1:0]                     len_eff;
	sdsplit_pkg::cell_ctl_t            ctl;
	logic [sdsplit_pkg::MAX_DELIM-1:0] sel;
	logic [7:0]                        oldest;
	logic                              all_eq;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dlen_q   <= 4'd1;
			dbytes_q <= '0;
			maxs_q   <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				sdsplit_pkg::CFG_DELIM_LEN:   dlen_q   <= cfg_data[3:0];
				sdsplit_pkg::CFG_DELIM_BYTES: dbytes_q <= cfg_data;
				sdsplit_pkg::CFG_MAX_SPLITS:  maxs_q   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (dlen_q == 4'd0) begin
			len_eff = LW'(1);
		end else if (int'(dlen_q) > sdsplit_pkg::MAX_DELIM) begin
			len_eff = LW'(sdsplit_pkg::MAX_DELIM);
		end else begin
			len_eff = LW'(dlen_q);
		end
	end

	sdsplit_window u_window (
		.clk         (clk),
		.ctl         (ctl),
		.sel         (sel),
		.len_eff     (len_eff),
		.delim_bytes (dbytes_q),
		.oldest      (oldest),
		.all_eq      (all_eq)
	);

	assign fire = pend_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !pend_q || (fire && done);
	assign splits_inc = (splits_q != 16'hFFFF) ? splits_q + 16'd1 : splits_q;

	always_comb begin
		phase_d      = phase_q;
		fill_d       = fill_q;
		ne_d         = ne_q;
		splits_d     = splits_q;
		stopped_d    = stopped_q;
		done         = 1'b0;
		run_end      = 1'b0;
		emit         = 1'b0;
		emit_kind    = sdsplit_pkg::KIND_BYTE;
		emit_byte    = 8'd0;
		ctl.shift    = 1'b0;
		ctl.new_byte = pbyte_q;
		sel          = '0;
		if (fire) begin
			case (phase_q)
				sdsplit_pkg::PH_RUN: begin
					if (stopped_q) begin
						emit      = 1'b1;
						emit_byte = pbyte_q;
						ne_d      = 1'b1;
						run_end   = 1'b1;
					end else if (LW'(fill_q) >= len_eff) begin
						// surplus after the length was lowered
						emit      = 1'b1;
						emit_byte = oldest;
						ctl.shift = 1'b1;
						fill_d    = fill_q - FW'(1);
						ne_d      = 1'b1;
					end else begin
						sel     = sdsplit_pkg::MAX_DELIM'(1) << fill_q;
						run_end = 1'b1;
						if (LW'(fill_q) + LW'(1) == len_eff) begin
							emit = 1'b1;
							if (all_eq) begin
								emit_kind = sdsplit_pkg::KIND_END;
								fill_d    = '0;
								ne_d      = 1'b0;
								splits_d  = splits_inc;
								if (maxs_q != 16'd0 && splits_inc >= maxs_q) begin
									stopped_d = 1'b1;
								end
							end else begin
								emit_byte = oldest;
								ctl.shift = 1'b1;
								ne_d      = 1'b1;
							end
						end else begin
							fill_d = fill_q + FW'(1);
						end
					end
					if (run_end) begin
						if (!plast_q) begin
							done = 1'b1;
						end else if (fill_d != '0) begin
							phase_d = sdsplit_pkg::PH_FLUSH;
						end else if (ne_d) begin
							phase_d = sdsplit_pkg::PH_MARK;
						end else begin
							done = 1'b1;
						end
					end
				end
				sdsplit_pkg::PH_FLUSH: begin
					emit      = 1'b1;
					emit_byte = oldest;
					ctl.shift = 1'b1;
					fill_d    = fill_q - FW'(1);
					ne_d      = 1'b1;
					if (fill_d == '0) begin
						phase_d = sdsplit_pkg::PH_MARK;
					end
				end
				sdsplit_pkg::PH_MARK: begin
					emit      = 1'b1;
					emit_kind = sdsplit_pkg::KIND_END;
					ne_d      = 1'b0;
					done      = 1'b1;
				end
				default: begin
					done = 1'b1;
				end
			endcase
			if (done) begin
				phase_d = sdsplit_pkg::PH_RUN;
				if (plast_q) begin
					fill_d    = '0;
					ne_d      = 1'b0;
					splits_d  = '0;
					stopped_d = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= sdsplit_pkg::PH_RUN;
			pend_q    <= 1'b0;
			fill_q    <= '0;
			ne_q      <= 1'b0;
			splits_q  <= '0;
			stopped_q <= 1'b0;
		end else begin
			phase_q   <= phase_d;
			fill_q    <= fill_d;
			ne_q      <= ne_d;
			splits_q  <= splits_d;
			stopped_q <= stopped_d;
			if (s_axis_tvalid && s_axis_tready) begin
				pend_q <= 1'b1;
			end else if (fire && done) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			pbyte_q <= s_axis_tdata;
			plast_q <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && emit) begin
			out_kind_q <= emit_kind;
			out_byte_q <= emit_byte;
			out_eos_q  <= plast_q && (emit_kind == sdsplit_pkg::KIND_END);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_byte_q;
	assign m_axis_tuser  = out_kind_q;
	assign m_axis_tlast  = out_eos_q;

	// window is empty once the split limit stops matching
	a_stop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		stopped_q |-> (fill_q == '0))
		else $error("window holds bytes after split limit");

	// draining never starts or continues on an empty window
	a_flush_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && phase_q == sdsplit_pkg::PH_FLUSH) |-> (fill_q != '0))
		else $error("flush on empty window");

	// end of string is only flagged on a field-end marker
	a_eos_marker: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tuser)
		else $error("end of string on a field byte");

	// string state is cleared after the final byte is finished
	a_string_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && done && plast_q) |=>
		(fill_q == '0 && splits_q == '0 && !stopped_q && !ne_q))
		else $error("string state not cleared at end of string");

endmodule
`default_nettype wire
